[design/assert_macros.svh]
// Assertion macros used by the scheduler RTL (pdas_back).
// Included by modules that check internal invariants; empty under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PDAS_CHECK(name, clk, rstn, prop) \
	name: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("pdas check failed");
`define PDAS_NEVER(name, clk, rstn, expr) \
	name: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
		else $error("pdas forbidden condition");
`else
`define PDAS_CHECK(name, clk, rstn, prop)
`define PDAS_NEVER(name, clk, rstn, expr)
`endif
`endif

[design/pdas_pkg.sv]
// Types and constants of the per-destination aggregation scheduler.
// No dependencies; used by pdas_front, pdas_back, the top level and the testbench.
package pdas_pkg;

	localparam int IN_DATA_W  = 104;
	localparam int OUT_DATA_W = 64;
	localparam int CFG_IDX_W  = 2;
	localparam int MAX_OUT    = 16;
	localparam int K_W        = 5;
	localparam int FRAME_W    = 14;
	localparam int BYTES_W    = 17;
	localparam logic [BYTES_W-1:0] BYTES_MAX = 17'h1FFFF;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_SIZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_SIZE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd2;

	typedef enum logic [2:0] {
		ST_ACCEPTED   = 3'd0,
		ST_TABLE_FULL = 3'd1,
		ST_FIFO_FULL  = 3'd2,
		ST_NOTHING    = 3'd3,
		ST_SENT       = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ENQ_SCAN,
		S_ENQ_UPD,
		S_DEQ_SCAN,
		S_DEQ_PICK,
		S_DEQ_SEL,
		S_DEQ_RD,
		S_DEQ_PROC,
		S_DEQ_FIN,
		S_DEQ_DLW,
		S_RESP
	} state_t;

	typedef struct packed {
		logic        func;
		logic [31:0] dest;
		logic [11:0] pkt_len;
		logic [9:0]  pkt_handle;
		logic [11:0] mark_limit;
		logic [31:0] now;
	} item_t;

endpackage

[design/pdas_ram.sv]
// Generic single-port RAM with registered read.
// No dependencies.
module pdas_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

[design/pdas_front.sv]
// Input side: accepts words, decodes them into items, queues two of them.
// Depends on pdas_pkg.
module pdas_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [pdas_pkg::IN_DATA_W-1:0] s_tdata,
	input  logic                           s_tuser,
	output logic                           item_valid,
	input  logic                           item_ready,
	output pdas_pkg::item_t                item
);

	pdas_pkg::item_t q_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      cnt_q;
	pdas_pkg::item_t dec;
	logic            push;
	logic            pop;

	always_comb begin
		dec.func       = s_tuser;
		dec.dest       = s_tdata[31:0];
		dec.pkt_len    = s_tdata[43:32];
		dec.pkt_handle = s_tdata[53:44];
		dec.mark_limit = s_tdata[65:54];
		dec.now        = s_tdata[97:66];
	end

	assign s_tready   = cnt_q != 2'd2;
	assign item_valid = cnt_q != 2'd0;
	assign item       = q_q[rd_ptr_q];
	assign push       = s_tvalid && s_tready;
	assign pop        = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_ptr_q] <= dec;
		end
	end

endmodule

[design/pdas_back.sv]
// Execution side: entry table, descriptor FIFOs, scan and dequeue sequencer.
// Depends on pdas_pkg, pdas_ram and assert_macros.svh.
`include "assert_macros.svh"
module pdas_back #(
	parameter int ENTRY_COUNT    = 16,
	parameter int FIFO_DEPTH     = 16,
	parameter int LINK_HDR_BYTES = 14,
	parameter int META_HDR_BYTES = 20
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  pdas_pkg::item_t                 item,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pdas_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                     cfg_data,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [pdas_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic [2:0]                      m_tuser,
	output logic                            m_tlast
);

	localparam int EW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
	localparam int HW = $clog2(FIFO_DEPTH);
	localparam int CW = $clog2(FIFO_DEPTH + 1);
	localparam int PW = HW + 1;
	localparam int AW = $clog2(ENTRY_COUNT * FIFO_DEPTH);
	localparam int RW = 54;
	localparam int FW = pdas_pkg::FRAME_W;
	localparam int BW = pdas_pkg::BYTES_W;

	pdas_pkg::state_t  state_q, state_d;
	pdas_pkg::item_t   item_q;
	pdas_pkg::status_t resp_q;

	logic [15:0] min_q;
	logic [11:0] max_q;
	logic [31:0] tmo_q;

	logic [ENTRY_COUNT-1:0] ent_vld_q;
	logic [31:0]            ent_dest_q  [ENTRY_COUNT];
	logic [BW-1:0]          ent_bytes_q [ENTRY_COUNT];
	logic [11:0]            ent_limit_q [ENTRY_COUNT];
	logic [11:0]            ent_mark_q  [ENTRY_COUNT];
	logic [31:0]            ent_dl_q    [ENTRY_COUNT];
	logic [HW-1:0]          ent_head_q  [ENTRY_COUNT];
	logic [CW-1:0]          ent_cnt_q   [ENTRY_COUNT];

	logic [EW-1:0] idx_q;
	logic          new_q;
	logic          mt_found_q, fr_found_q, bt_found_q, bs_found_q;
	logic [EW-1:0] mt_idx_q, fr_idx_q, bt_idx_q, bs_idx_q;
	logic [31:0]   bt_dl_q;
	logic [BW-1:0] bs_bytes_q;
	logic          timed_q, agg_q, pend_first_q;
	logic [11:0]   limit_q;
	logic [pdas_pkg::K_W-1:0] k_q;
	logic [FW-1:0] frame_q, meta_q;
	logic [9:0]    pend_handle_q;

	logic          out_vld_q;
	logic [2:0]    o_status_q;
	logic [9:0]    o_handle_q;
	logic [31:0]   o_dest_q;
	logic          o_agg_q, o_first_q, o_last_q, o_bt_q;
	logic [15:0]   o_meta_q;

	logic [31:0]   cur_dest, cur_dl;
	logic [BW-1:0] cur_bytes;
	logic [HW-1:0] cur_head;
	logic [CW-1:0] cur_cnt;
	logic          cur_vld, last_idx, match_now;
	logic          mt_hit, fr_hit;
	logic [EW-1:0] mt_e, fr_e;
	logic [32:0]   dl_sum;
	logic [31:0]   dl;
	logic [11:0]   p_in, p_slot;
	logic [BW:0]   bytes_sum;
	logic          out_free, fifo_full, fit, take, more, stop_fit;
	logic          emit_mid, emit_fin, emit_resp;
	logic [HW-1:0] pos_head;
	logic [CW-1:0] pos_off;
	logic [PW-1:0] pos_sum;
	logic [HW-1:0] pos;
	logic [AW-1:0] ram_addr;
	logic          ram_we, ram_re;
	logic [RW-1:0] ram_wdata, ram_rdata;
	logic [9:0]    rd_handle;
	logic [31:0]   rd_dl;
	logic [HW-1:0] head_inc;
	logic [CW-1:0] cnt_left;

	assign cur_vld   = ent_vld_q[idx_q];
	assign cur_dest  = ent_dest_q[idx_q];
	assign cur_dl    = ent_dl_q[idx_q];
	assign cur_bytes = ent_bytes_q[idx_q];
	assign cur_head  = ent_head_q[idx_q];
	assign cur_cnt   = ent_cnt_q[idx_q];
	assign last_idx  = idx_q == EW'(ENTRY_COUNT - 1);
	assign match_now = cur_vld && (cur_dest == item_q.dest);
	assign mt_hit    = mt_found_q || match_now;
	assign mt_e      = mt_found_q ? mt_idx_q : idx_q;
	assign fr_hit    = fr_found_q || !cur_vld;
	assign fr_e      = fr_found_q ? fr_idx_q : idx_q;

	assign dl_sum = {1'b0, item_q.now} + {1'b0, tmo_q};
	assign dl     = dl_sum[32] ? 32'hFFFF_FFFF : dl_sum[31:0];
	assign p_in   = (item_q.pkt_len > 12'(LINK_HDR_BYTES)) ?
		item_q.pkt_len - 12'(LINK_HDR_BYTES) : 12'd0;
	assign bytes_sum = (new_q ? {(BW + 1){1'b0}} : {1'b0, cur_bytes}) + (BW + 1)'(p_in);
	assign fifo_full = !new_q && (cur_cnt >= CW'(FIFO_DEPTH));

	assign rd_handle = ram_rdata[9:0];
	assign p_slot    = (ram_rdata[21:10] > 12'(LINK_HDR_BYTES)) ?
		ram_rdata[21:10] - 12'(LINK_HDR_BYTES) : 12'd0;
	assign rd_dl     = ram_rdata[53:22];
	assign ram_wdata = {dl, item_q.pkt_len, item_q.pkt_handle};

	assign out_free = !out_vld_q || m_tready;
	assign fit      = (frame_q + FW'(p_slot)) <= FW'(limit_q);
	assign take     = (k_q == '0) || (fit && out_free);
	assign stop_fit = (k_q != '0) && !fit;
	assign cnt_left = cur_cnt - CW'(1);
	assign more     = (cnt_left != '0) && ((k_q + 1'b1) < pdas_pkg::K_W'(pdas_pkg::MAX_OUT));
	assign head_inc = (cur_head == HW'(FIFO_DEPTH - 1)) ? '0 : cur_head + 1'b1;

	assign emit_mid  = (state_q == pdas_pkg::S_DEQ_PROC) && (k_q != '0) && fit && out_free;
	assign emit_fin  = (state_q == pdas_pkg::S_DEQ_FIN) && out_free;
	assign emit_resp = (state_q == pdas_pkg::S_RESP) && out_free;

	assign pos_head = (state_q == pdas_pkg::S_ENQ_UPD && new_q) ? '0 : cur_head;
	assign pos_off  = (state_q == pdas_pkg::S_ENQ_UPD && !new_q) ? cur_cnt : '0;
	assign pos_sum  = PW'(pos_head) + PW'(pos_off);
	assign pos      = (pos_sum >= PW'(FIFO_DEPTH)) ? HW'(pos_sum - PW'(FIFO_DEPTH)) :
		HW'(pos_sum);
	assign ram_addr = AW'(idx_q) * AW'(FIFO_DEPTH) + AW'(pos);
	assign ram_we   = (state_q == pdas_pkg::S_ENQ_UPD) && !fifo_full;
	assign ram_re   = (state_q == pdas_pkg::S_DEQ_RD) ||
		(emit_fin && (cur_cnt != '0));

	assign item_ready = state_q == pdas_pkg::S_IDLE;
	assign cfg_ready  = 1'b1;

	pdas_ram #(.WIDTH(RW), .DEPTH(ENTRY_COUNT * FIFO_DEPTH)) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pdas_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			pdas_pkg::S_IDLE: begin
				if (item_valid) begin
					state_d = item.func ? pdas_pkg::S_DEQ_SCAN : pdas_pkg::S_ENQ_SCAN;
				end
			end
			pdas_pkg::S_ENQ_SCAN: begin
				if (last_idx) begin
					state_d = (mt_hit || fr_hit) ? pdas_pkg::S_ENQ_UPD : pdas_pkg::S_RESP;
				end
			end
			pdas_pkg::S_ENQ_UPD: state_d = pdas_pkg::S_RESP;
			pdas_pkg::S_DEQ_SCAN: begin
				if (last_idx) state_d = pdas_pkg::S_DEQ_PICK;
			end
			pdas_pkg::S_DEQ_PICK: begin
				if (bt_found_q || (bs_found_q && bs_bytes_q > BW'(min_q))) begin
					state_d = pdas_pkg::S_DEQ_SEL;
				end else begin
					state_d = pdas_pkg::S_RESP;
				end
			end
			pdas_pkg::S_DEQ_SEL: begin
				state_d = (cur_cnt == '0) ? pdas_pkg::S_RESP : pdas_pkg::S_DEQ_RD;
			end
			pdas_pkg::S_DEQ_RD: state_d = pdas_pkg::S_DEQ_PROC;
			pdas_pkg::S_DEQ_PROC: begin
				if (take) begin
					state_d = more ? pdas_pkg::S_DEQ_RD : pdas_pkg::S_DEQ_FIN;
				end else if (stop_fit) begin
					state_d = pdas_pkg::S_DEQ_FIN;
				end
			end
			pdas_pkg::S_DEQ_FIN: begin
				if (out_free) begin
					state_d = (cur_cnt == '0) ? pdas_pkg::S_IDLE : pdas_pkg::S_DEQ_DLW;
				end
			end
			pdas_pkg::S_DEQ_DLW: state_d = pdas_pkg::S_IDLE;
			pdas_pkg::S_RESP: begin
				if (out_free) state_d = pdas_pkg::S_IDLE;
			end
			default: state_d = pdas_pkg::S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q      <= 16'd500;
			max_q      <= 12'd1500;
			tmo_q      <= 32'd1000;
			ent_vld_q  <= '0;
			ent_head_q <= '{default: '0};
			ent_cnt_q  <= '{default: '0};
			idx_q      <= '0;
			out_vld_q  <= 1'b0;
			k_q        <= '0;
			mt_found_q <= 1'b0;
			fr_found_q <= 1'b0;
			bt_found_q <= 1'b0;
			bs_found_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					pdas_pkg::CFG_MIN_SIZE: min_q <= cfg_data[15:0];
					pdas_pkg::CFG_MAX_SIZE: max_q <= cfg_data[11:0];
					pdas_pkg::CFG_TIMEOUT:  tmo_q <= cfg_data;
					default: ;
				endcase
			end
			if (emit_mid || emit_fin || emit_resp) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				pdas_pkg::S_IDLE: begin
					idx_q      <= '0;
					mt_found_q <= 1'b0;
					fr_found_q <= 1'b0;
					bt_found_q <= 1'b0;
					bs_found_q <= 1'b0;
				end
				pdas_pkg::S_ENQ_SCAN: begin
					if (match_now) mt_found_q <= 1'b1;
					if (!cur_vld) fr_found_q <= 1'b1;
					if (last_idx) begin
						idx_q <= mt_hit ? mt_e : fr_e;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				pdas_pkg::S_ENQ_UPD: begin
					if (!fifo_full) begin
						ent_vld_q[idx_q] <= 1'b1;
						if (new_q) begin
							ent_head_q[idx_q] <= '0;
							ent_cnt_q[idx_q]  <= CW'(1);
						end else begin
							ent_cnt_q[idx_q] <= cur_cnt + 1'b1;
						end
					end
				end
				pdas_pkg::S_DEQ_SCAN: begin
					if (cur_vld && cur_dl <= item_q.now &&
						(!bt_found_q || cur_dl < bt_dl_q)) begin
						bt_found_q <= 1'b1;
					end
					if (cur_vld) bs_found_q <= 1'b1;
					if (!last_idx) idx_q <= idx_q + 1'b1;
				end
				pdas_pkg::S_DEQ_PICK: begin
					idx_q <= bt_found_q ? bt_idx_q : bs_idx_q;
				end
				pdas_pkg::S_DEQ_SEL: k_q <= '0;
				pdas_pkg::S_DEQ_PROC: begin
					if (take) begin
						ent_head_q[idx_q] <= head_inc;
						ent_cnt_q[idx_q]  <= cnt_left;
						k_q               <= k_q + 1'b1;
					end
				end
				pdas_pkg::S_DEQ_FIN: begin
					if (out_free && cur_cnt == '0) ent_vld_q[idx_q] <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == pdas_pkg::S_IDLE && item_valid) item_q <= item;
		case (state_q)
			pdas_pkg::S_ENQ_SCAN: begin
				if (match_now && !mt_found_q) mt_idx_q <= idx_q;
				if (!cur_vld && !fr_found_q) fr_idx_q <= idx_q;
				if (last_idx) begin
					new_q  <= !mt_hit;
					resp_q <= pdas_pkg::ST_TABLE_FULL;
				end
			end
			pdas_pkg::S_ENQ_UPD: begin
				resp_q <= fifo_full ? pdas_pkg::ST_FIFO_FULL : pdas_pkg::ST_ACCEPTED;
				if (!fifo_full) begin
					ent_mark_q[idx_q]  <= item_q.mark_limit;
					ent_bytes_q[idx_q] <= bytes_sum[BW] ? pdas_pkg::BYTES_MAX :
						bytes_sum[BW-1:0];
					if (new_q) begin
						ent_dest_q[idx_q]  <= item_q.dest;
						ent_limit_q[idx_q] <= (max_q != '0) ? max_q : item_q.mark_limit;
						ent_dl_q[idx_q]    <= dl;
					end
				end
			end
			pdas_pkg::S_DEQ_SCAN: begin
				if (cur_vld && cur_dl <= item_q.now &&
					(!bt_found_q || cur_dl < bt_dl_q)) begin
					bt_idx_q <= idx_q;
					bt_dl_q  <= cur_dl;
				end
				if (cur_vld && (!bs_found_q || cur_bytes > bs_bytes_q)) begin
					bs_idx_q   <= idx_q;
					bs_bytes_q <= cur_bytes;
				end
			end
			pdas_pkg::S_DEQ_PICK: begin
				timed_q <= bt_found_q;
				resp_q  <= pdas_pkg::ST_NOTHING;
			end
			pdas_pkg::S_DEQ_SEL: begin
				agg_q   <= cur_cnt > CW'(1);
				limit_q <= (max_q == '0) ? ent_mark_q[idx_q] : ent_limit_q[idx_q];
				if (max_q == '0) ent_limit_q[idx_q] <= ent_mark_q[idx_q];
			end
			pdas_pkg::S_DEQ_PROC: begin
				if (take) begin
					ent_bytes_q[idx_q] <= (cur_bytes > BW'(p_slot)) ?
						cur_bytes - BW'(p_slot) : '0;
					pend_handle_q <= rd_handle;
					pend_first_q  <= k_q == '0;
					if (k_q == '0) begin
						frame_q <= FW'(LINK_HDR_BYTES + META_HDR_BYTES) + FW'(p_slot);
						meta_q  <= FW'(META_HDR_BYTES) + FW'(p_slot);
					end else begin
						frame_q <= frame_q + FW'(p_slot);
						meta_q  <= meta_q + FW'(p_slot);
					end
				end
			end
			pdas_pkg::S_DEQ_FIN: begin
				if (out_free && cur_cnt == '0) ent_bytes_q[idx_q] <= '0;
			end
			pdas_pkg::S_DEQ_DLW: ent_dl_q[idx_q] <= rd_dl;
			default: ;
		endcase
		if (emit_mid || emit_fin) begin
			o_status_q <= pdas_pkg::ST_SENT;
			o_handle_q <= pend_handle_q;
			o_dest_q   <= cur_dest;
			o_agg_q    <= agg_q;
			o_first_q  <= pend_first_q;
			o_last_q   <= emit_fin;
			o_meta_q   <= (emit_fin && agg_q) ? 16'(meta_q) : 16'd0;
			o_bt_q     <= timed_q;
		end else if (emit_resp) begin
			o_status_q <= resp_q;
			o_handle_q <= '0;
			o_dest_q   <= '0;
			o_agg_q    <= 1'b0;
			o_first_q  <= 1'b0;
			o_last_q   <= 1'b1;
			o_meta_q   <= '0;
			o_bt_q     <= 1'b0;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = o_status_q;
	assign m_tlast  = o_last_q;
	assign m_tdata  = {3'b000, o_bt_q, o_meta_q, o_first_q, o_agg_q, o_dest_q, o_handle_q};

	`PDAS_CHECK(a_cnt_bound, clk, arst_n, ent_cnt_q[idx_q] <= CW'(FIFO_DEPTH))
	`PDAS_CHECK(a_proc_entry, clk, arst_n, (state_q == pdas_pkg::S_DEQ_PROC) |-> ent_vld_q[idx_q])
	`PDAS_NEVER(a_k_cap, clk, arst_n, (state_q == pdas_pkg::S_DEQ_PROC) && (k_q >= pdas_pkg::K_W'(pdas_pkg::MAX_OUT)))

endmodule

[design/per_destination_aggregation_scheduler.sv]
// Top level of the per-destination aggregation scheduler.
// Depends on pdas_pkg, pdas_front, pdas_back (and pdas_ram below it).
//
// channel | direction | handshake          | payload
// s_      | in        | s_tvalid/s_tready  | s_tuser func, s_tdata item fields
// m_      | out       | m_tvalid/m_tready  | m_tuser status, m_tdata, m_tlast
// cfg_    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// An enqueue scans the table one entry at a time, then updates the found entry (or
// a free one) and responds. A dequeue scans the table and picks an entry; with nothing
// due it responds, else it reads and processes each descriptor in turn (the one that
// does not fit is read too), sends the last word and loads the new head deadline when the entry stays.
// Reset clears the entry valid bits and FIFO pointers at once; no sweep.
// A stalled result stalls the sequencer; two words queue at the input.
module per_destination_aggregation_scheduler #(
	parameter int ENTRY_COUNT    = 16,
	parameter int FIFO_DEPTH     = 16,
	parameter int LINK_HDR_BYTES = 14,
	parameter int META_HDR_BYTES = 20
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// dest[31:0], pkt_len[43:32], pkt_handle[53:44], mark_limit[65:54], now[97:66]
	input  logic [pdas_pkg::IN_DATA_W-1:0]  s_tdata,
	// func[0]
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// out_handle[9:0], out_dest[41:10], aggregated[42], first[43],
	// meta_len[59:44], by_timeout[60]
	output logic [pdas_pkg::OUT_DATA_W-1:0] m_tdata,
	// status[2:0]
	output logic [2:0]                      m_tuser,
	output logic                            m_tlast,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pdas_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                     cfg_data
);

	logic            item_valid;
	logic            item_ready;
	pdas_pkg::item_t item;

	pdas_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item)
	);

	pdas_back #(
		.ENTRY_COUNT    (ENTRY_COUNT),
		.FIFO_DEPTH     (FIFO_DEPTH),
		.LINK_HDR_BYTES (LINK_HDR_BYTES),
		.META_HDR_BYTES (META_HDR_BYTES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule

[verif/testbench.sv]
// Self-checking testbench for per_destination_aggregation_scheduler.
// Uses pdas_pkg types; predicts every result word in-line and compares on the
// master stream. Directed table first, then random bursts under config phases.
`timescale 1ns / 100ps

module testbench;

	localparam int NENT = 16;
	localparam int DEPTH = 16;
	localparam int LINK_HDR = 14;
	localparam int META_HDR = 20;
	localparam int IDLE_LIMIT = 4000;

	typedef struct {
		pdas_pkg::status_t st;
		logic [9:0]  hdl;
		logic [31:0] dst;
		logic        agg;
		logic        fst;
		logic        lst;
		logic [15:0] ml;
		logic        bt;
	} sched_word_t;

	typedef struct {
		logic        func;
		logic [31:0] dest;
		logic [11:0] len;
		logic [9:0]  hdl;
		logic [11:0] mark;
		logic [31:0] now;
		bit          chk;
		pdas_pkg::status_t st;
	} stim_row_t;

	typedef struct {
		bit      chk;
		pdas_pkg::status_t st;
	} typed_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [pdas_pkg::IN_DATA_W-1:0] s_tdata = '0;
	logic s_tuser = 0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [pdas_pkg::OUT_DATA_W-1:0] m_tdata;
	logic [2:0] m_tuser;
	logic m_tlast;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [pdas_pkg::CFG_IDX_W-1:0] cfg_index = pdas_pkg::CFG_MIN_SIZE;
	logic [31:0] cfg_data = '0;

	per_destination_aggregation_scheduler u_top (.*);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	// predictor state
	logic [15:0] min_sz;
	logic [11:0] max_sz;
	logic [31:0] tmo;
	bit          ent_valid [NENT];
	logic [31:0] ent_dest [NENT];
	int unsigned ent_bytes [NENT];
	logic [11:0] ent_limit [NENT];
	logic [11:0] ent_mark [NENT];
	logic [31:0] ent_deadline [NENT];
	int unsigned ent_head [NENT];
	int unsigned ent_count [NENT];
	logic [9:0]  slot_hdl [NENT*DEPTH];
	logic [11:0] slot_len [NENT*DEPTH];
	logic [31:0] slot_dl [NENT*DEPTH];

	sched_word_t expected_q[$];
	typed_t typed_q[$];
	int errors = 0;
	int n_items = 0, n_words = 0, n_cfg = 0;
	int status_seen [5];
	int max_burst = 0;
	int snd_idle = 0, rcv_idle = 0;
	int hold_cnt = 0;
	int idle_cycles = 0;

	function automatic int unsigned payload(logic [11:0] len);
		return len > LINK_HDR ? len - LINK_HDR : 0;
	endfunction

	function automatic int slot_of(int e, int i);
		return e * DEPTH + (ent_head[e] + i) % DEPTH;
	endfunction

	function automatic void push_word(pdas_pkg::status_t st, logic [9:0] h, logic [31:0] d,
			bit agg, bit f, bit l, logic [15:0] ml, bit bt);
		sched_word_t w;
		w.st = st; w.hdl = h; w.dst = d; w.agg = agg; w.fst = f; w.lst = l;
		w.ml = ml; w.bt = bt;
		expected_q.push_back(w);
	endfunction

	function automatic void pop_head(int e);
		int unsigned p;
		p = payload(slot_len[slot_of(e, 0)]);
		ent_bytes[e] = ent_bytes[e] > p ? ent_bytes[e] - p : 0;
		ent_head[e] = (ent_head[e] + 1) % DEPTH;
		ent_count[e]--;
	endfunction

	function automatic void sched_reset();
		min_sz = 500; max_sz = 1500; tmo = 1000;
		for (int i = 0; i < NENT; i++) begin
			ent_valid[i] = 0; ent_head[i] = 0; ent_count[i] = 0;
		end
	endfunction

	// returns the status of the first word produced
	function automatic pdas_pkg::status_t predict_schedule(pdas_pkg::item_t it);
		int e, bt, bs, k, s;
		logic [31:0] dl;
		int unsigned sum, frame, meta, p;
		bit timed;
		e = -1; bt = -1; bs = -1; timed = 0;
		if (!it.func) begin
			dl = it.now + tmo;
			if (dl < it.now) dl = '1;
			for (int i = 0; i < NENT; i++)
				if (e < 0 && ent_valid[i] && ent_dest[i] == it.dest) e = i;
			if (e < 0) begin
				for (int i = 0; i < NENT; i++)
					if (e < 0 && !ent_valid[i]) e = i;
				if (e < 0) begin
					push_word(pdas_pkg::ST_TABLE_FULL, 10'd0, 32'd0, 1'b0, 1'b0, 1'b1,
						16'd0, 1'b0);
					return pdas_pkg::ST_TABLE_FULL;
				end
				ent_valid[e] = 1; ent_dest[e] = it.dest; ent_bytes[e] = 0;
				ent_limit[e] = max_sz != 0 ? max_sz : it.mark_limit;
				ent_deadline[e] = dl; ent_head[e] = 0; ent_count[e] = 0;
			end else if (ent_count[e] >= DEPTH) begin
				push_word(pdas_pkg::ST_FIFO_FULL, 10'd0, 32'd0, 1'b0, 1'b0, 1'b1, 16'd0, 1'b0);
				return pdas_pkg::ST_FIFO_FULL;
			end
			s = slot_of(e, ent_count[e]);
			slot_hdl[s] = it.pkt_handle; slot_len[s] = it.pkt_len; slot_dl[s] = dl;
			ent_count[e]++;
			ent_mark[e] = it.mark_limit;
			sum = ent_bytes[e] + payload(it.pkt_len);
			ent_bytes[e] = sum > pdas_pkg::BYTES_MAX ? pdas_pkg::BYTES_MAX : sum;
			push_word(pdas_pkg::ST_ACCEPTED, 10'd0, 32'd0, 1'b0, 1'b0, 1'b1, 16'd0, 1'b0);
			return pdas_pkg::ST_ACCEPTED;
		end
		for (int i = 0; i < NENT; i++) begin
			if (ent_valid[i]) begin
				if (ent_deadline[i] <= it.now && (bt < 0 || ent_deadline[i] < ent_deadline[bt]))
					bt = i;
				if (bs < 0 || ent_bytes[i] > ent_bytes[bs]) bs = i;
			end
		end
		if (bt >= 0) begin
			e = bt; timed = 1;
		end else if (bs >= 0 && ent_bytes[bs] > min_sz) e = bs;
		if (e < 0 || ent_count[e] == 0) begin
			push_word(pdas_pkg::ST_NOTHING, 10'd0, 32'd0, 1'b0, 1'b0, 1'b1, 16'd0, 1'b0);
			return pdas_pkg::ST_NOTHING;
		end
		if (max_sz == 0) ent_limit[e] = ent_mark[e];
		if (ent_count[e] == 1) begin
			push_word(pdas_pkg::ST_SENT, slot_hdl[slot_of(e, 0)], ent_dest[e], 1'b0, 1'b1,
				1'b1, 16'd0, timed);
			pop_head(e);
			k = 1;
		end else begin
			meta = META_HDR + payload(slot_len[slot_of(e, 0)]);
			frame = LINK_HDR + meta;
			push_word(pdas_pkg::ST_SENT, slot_hdl[slot_of(e, 0)], ent_dest[e], 1'b1, 1'b1,
				1'b0, 16'd0, timed);
			pop_head(e);
			k = 1;
			while (k < pdas_pkg::MAX_OUT && ent_count[e] > 0) begin
				s = slot_of(e, 0);
				p = payload(slot_len[s]);
				if (frame + p > ent_limit[e]) break;
				frame += p;
				meta += p;
				push_word(pdas_pkg::ST_SENT, slot_hdl[s], ent_dest[e], 1'b1, 1'b0, 1'b0,
					16'd0, timed);
				pop_head(e);
				k++;
			end
			expected_q[$].lst = 1;
			expected_q[$].ml = meta[15:0];
		end
		if (k > max_burst) max_burst = k;
		if (ent_count[e] == 0) begin
			ent_valid[e] = 0; ent_bytes[e] = 0;
		end else ent_deadline[e] = slot_dl[slot_of(e, 0)];
		return pdas_pkg::ST_SENT;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		errors++;
		$display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
	endtask

	// monitor: prediction, checking, config mirror, watchdog
	always @(posedge clk) begin
		pdas_pkg::item_t it;
		typed_t ty;
		sched_word_t w;
		pdas_pkg::status_t first_st;
		bit busy;
		busy = 0;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				busy = 1;
				it.func = s_tuser; it.dest = s_tdata[31:0]; it.pkt_len = s_tdata[43:32];
				it.pkt_handle = s_tdata[53:44]; it.mark_limit = s_tdata[65:54];
				it.now = s_tdata[97:66];
				first_st = predict_schedule(it);
				n_items++;
				ty = typed_q.pop_front();
				if (ty.chk && first_st != ty.st)
					report_mismatch("table status", 64'(first_st), 64'(ty.st));
			end
			if (cfg_valid && cfg_ready) begin
				busy = 1;
				n_cfg++;
				case (cfg_index)
					pdas_pkg::CFG_MIN_SIZE: min_sz = cfg_data[15:0];
					pdas_pkg::CFG_MAX_SIZE: max_sz = cfg_data[11:0];
					pdas_pkg::CFG_TIMEOUT: tmo = cfg_data;
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				busy = 1;
				n_words++;
				if (m_tuser <= 4) status_seen[m_tuser]++;
				if (expected_q.size() == 0) begin
					report_mismatch("unexpected word", m_tdata, 64'd0);
				end else begin
					w = expected_q.pop_front();
					if (m_tuser !== w.st)
						report_mismatch("status", 64'(m_tuser), 64'(w.st));
					if (m_tdata[9:0] !== w.hdl)
						report_mismatch("out_handle", 64'(m_tdata[9:0]), 64'(w.hdl));
					if (m_tdata[41:10] !== w.dst)
						report_mismatch("out_dest", 64'(m_tdata[41:10]), 64'(w.dst));
					if (m_tdata[42] !== w.agg)
						report_mismatch("aggregated", 64'(m_tdata[42]), 64'(w.agg));
					if (m_tdata[43] !== w.fst)
						report_mismatch("first", 64'(m_tdata[43]), 64'(w.fst));
					if (m_tlast !== w.lst)
						report_mismatch("last", 64'(m_tlast), 64'(w.lst));
					if (m_tdata[59:44] !== w.ml)
						report_mismatch("meta_len", 64'(m_tdata[59:44]), 64'(w.ml));
					if (m_tdata[60] !== w.bt)
						report_mismatch("by_timeout", 64'(m_tdata[60]), 64'(w.bt));
				end
			end
			idle_cycles <= busy ? 0 : idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// receiver: random stalls plus forced hold-off
	always @(posedge clk) begin
		if (hold_cnt > 0) begin
			m_tready <= 0;
			hold_cnt <= hold_cnt - 1;
		end else m_tready <= ($urandom_range(0, 99) >= rcv_idle);
	end

	task automatic send_item(logic func, logic [31:0] dest, logic [11:0] len, logic [9:0] hdl,
			logic [11:0] mark, logic [31:0] now, bit chk, pdas_pkg::status_t st);
		typed_t ty;
		if (snd_idle > 0 && $urandom_range(0, 99) < snd_idle) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		ty.chk = chk; ty.st = st;
		typed_q.push_back(ty);
		s_tvalid <= 1;
		s_tuser <= func;
		s_tdata <= {6'b0, now, mark, hdl, len, dest};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic write_reg(logic [pdas_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
		s_tvalid <= 0;
		wait (expected_q.size() == 0);
		@(posedge clk);
		repeat (60) @(posedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
	endtask

	logic [31:0] dest_pool [20];
	logic [31:0] cur_now;

	task automatic random_phase(int n_target);
		int n, burst;
		logic [31:0] d;
		n = 0;
		while (n < n_target) begin
			if ($urandom_range(0, 99) < 35) begin
				cur_now += $urandom_range(0, 600);
				send_item(1'b1, $urandom, 12'($urandom), 10'($urandom), 12'($urandom),
					($urandom_range(0, 19) == 0) ? $urandom : cur_now, 1'b0,
					pdas_pkg::ST_ACCEPTED);
				n++;
			end else begin
				d = ($urandom_range(0, 9) == 0) ? $urandom : dest_pool[$urandom_range(0, 19)];
				burst = ($urandom_range(0, 9) == 0) ? 18 : $urandom_range(1, 4);
				repeat (burst) begin
					cur_now += $urandom_range(0, 40);
					send_item(1'b0, d,
						($urandom_range(0, 4) == 0) ? 12'($urandom_range(0, 4095))
							: 12'($urandom_range(0, 300)),
						10'($urandom), 12'($urandom),
						($urandom_range(0, 29) == 0) ? $urandom : cur_now, 1'b0,
						pdas_pkg::ST_ACCEPTED);
					n++;
				end
			end
		end
	endtask

	stim_row_t dir_rows [] = '{
		'{1, 32'h0, 0, 0, 0, 32'h0, 1, pdas_pkg::ST_NOTHING},
		'{0, 32'h0, 0, 0, 0, 32'h0, 1, pdas_pkg::ST_ACCEPTED},
		'{0, 32'hFFFFFFFF, 12'hFFF, 10'h3FF, 12'hFFF, 32'hFFFFFF00, 1, pdas_pkg::ST_ACCEPTED},
		'{0, 32'h0, 13, 5, 100, 32'h1, 1, pdas_pkg::ST_ACCEPTED},
		'{0, 32'h0, 700, 6, 100, 32'h2, 1, pdas_pkg::ST_ACCEPTED},
		'{0, 32'h0, 800, 7, 200, 32'h3, 1, pdas_pkg::ST_ACCEPTED},
		'{1, 32'h0, 0, 0, 0, 32'd10, 1, pdas_pkg::ST_SENT},
		'{1, 32'h0, 0, 0, 0, 32'd10, 0, pdas_pkg::ST_SENT},
		'{1, 32'h0, 0, 0, 0, 32'd2000, 0, pdas_pkg::ST_SENT},
		'{1, 32'h0, 0, 0, 0, 32'd2000, 1, pdas_pkg::ST_NOTHING},
		'{0, 32'hA5A5A5A5, 100, 10'h2AA, 12'hAAA, 32'd5000, 1, pdas_pkg::ST_ACCEPTED},
		'{0, 32'hA5A5A5A5, 100, 10'h155, 12'h555, 32'd5000, 1, pdas_pkg::ST_ACCEPTED},
		'{0, 32'h5A5A5A5A, 14, 9, 1, 32'd5000, 1, pdas_pkg::ST_ACCEPTED},
		'{1, 32'h0, 0, 0, 0, 32'd5000, 1, pdas_pkg::ST_NOTHING},
		'{1, 32'h0, 0, 0, 0, 32'd7000, 0, pdas_pkg::ST_SENT},
		'{1, 32'h0, 0, 0, 0, 32'd7000, 0, pdas_pkg::ST_SENT},
		'{1, 32'h0, 0, 0, 0, 32'd7000, 1, pdas_pkg::ST_NOTHING}
	};

	initial begin
		int wait_cnt;
		sched_reset();
		cur_now = 32'd10000;
		foreach (dest_pool[i]) dest_pool[i] = $urandom;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (dir_rows[i])
			send_item(dir_rows[i].func, dir_rows[i].dest, dir_rows[i].len, dir_rows[i].hdl,
				dir_rows[i].mark, dir_rows[i].now, dir_rows[i].chk, dir_rows[i].st);

		// mark-driven limit, eager sending, short timeout
		snd_idle = 17; rcv_idle = 78;
		write_reg(pdas_pkg::CFG_MAX_SIZE, 32'd0);
		write_reg(pdas_pkg::CFG_MIN_SIZE, 32'd0);
		write_reg(pdas_pkg::CFG_TIMEOUT, 32'd1);
		random_phase(70);

		snd_idle = 78; rcv_idle = 17;
		write_reg(pdas_pkg::CFG_MIN_SIZE, 32'hFFFF);
		write_reg(pdas_pkg::CFG_MAX_SIZE, 32'd2048);
		write_reg(pdas_pkg::CFG_TIMEOUT, 32'd300);
		random_phase(70);

		// no idling; long receiver hold-off fills the block
		snd_idle = 0; rcv_idle = 0;
		write_reg(pdas_pkg::CFG_MIN_SIZE, 32'd300);
		write_reg(pdas_pkg::CFG_MAX_SIZE, 32'd1500);
		write_reg(pdas_pkg::CFG_TIMEOUT, 32'hFFFFFFFF);
		hold_cnt = 400;
		random_phase(70);
		write_reg(pdas_pkg::CFG_TIMEOUT, 32'd700);
		random_phase(20);

		s_tvalid <= 0;
		wait_cnt = 0;
		while (expected_q.size() != 0 && wait_cnt < 20000) begin
			@(posedge clk);
			wait_cnt++;
		end
		repeat (100) @(posedge clk);
		if (expected_q.size() != 0) begin
			errors++;
			$display("%0d expected words never arrived", expected_q.size());
		end
		$display("covered %0d items, %0d result words, %0d register writes", n_items, n_words,
			n_cfg);
		$display("status counts acc/tfull/ffull/none/sent %0d/%0d/%0d/%0d/%0d, longest burst %0d",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4],
			max_burst);
		if (errors == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end

endmodule

[per_destination_aggregation_scheduler.f]
+incdir+design
design/pdas_pkg.sv
design/pdas_ram.sv
design/pdas_front.sv
design/pdas_back.sv
design/per_destination_aggregation_scheduler.sv
verif/testbench.sv
